// ----- hdl/grid_city_block_distance_bands_unit_macros.svh -----
// Assertion macros for the grid city-block distance band unit.
// Included by the RTL files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef GRID_CITY_BLOCK_DISTANCE_BANDS_UNIT_MACROS_SVH
`define GRID_CITY_BLOCK_DISTANCE_BANDS_UNIT_MACROS_SVH

// same-cycle implication
`define GCB_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcb assertion failed");

// next-cycle implication
`define GCB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcb assertion failed");

`endif

// ----- hdl/gcb_pkg.sv -----
// Shared constants, types and helper functions of the grid distance band unit.
// No dependencies; used by gcb_scan, grid_city_block_distance_bands_unit and the test bench.
`default_nettype none

package gcb_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int COORD_W  = 8;
    localparam int SIZE_W   = 9;
    localparam int THR_W    = 4;
    localparam int DIST_W   = 9;
    localparam int OP_W     = 2;
    localparam int BAND_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
    localparam logic [SIZE_W-1:0] COLS_LIM = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] ROWS_LIM = SIZE_W'(MAX_ROWS);

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [BAND_W-1:0] BAND_NONE = 2'd0;
    localparam logic [BAND_W-1:0] BAND_EDGE = 2'd1;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd2;
    localparam logic [BAND_W-1:0] BAND_DEEP = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MAX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_MAX     = 2'd3;

    localparam logic [SIZE_W-1:0] RST_GRID_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_GRID_HEIGHT = 9'd256;
    localparam logic [THR_W-1:0]  RST_EDGE_MAX    = 4'd2;
    localparam logic [THR_W-1:0]  RST_MID_MAX     = 4'd5;

    typedef struct packed {
        logic                mask_re;
        logic [ADDR_W-1:0]   mask_raddr;
        logic                dist_re;
        logic [ADDR_W-1:0]   dist_raddr;
        logic                dist_we;
        logic [ADDR_W-1:0]   dist_waddr;
        logic [DIST_W-1:0]   dist_wdata;
    } scan_ram_t;

    function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COORD_W-1:0] r,
                                                     input logic [COORD_W-1:0] c);
        pixel_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
        sat_inc = (d == DIST_SAT) ? DIST_SAT : d + DIST_W'(1);
    endfunction

    function automatic logic [DIST_W-1:0] min_dist(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        min_dist = (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gcb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module gcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/gcb_scan.sv -----
// Two-pass raster scan sequencer for the city-block distance transform.
// Drives the mask and distance memory ports; depends on gcb_pkg.
`default_nettype none

module gcb_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          done_ack,
    input  wire logic [gcb_pkg::SIZE_W-1:0]    w_eff,
    input  wire logic [gcb_pkg::SIZE_W-1:0]    h_eff,
    input  wire logic [gcb_pkg::THR_W-1:0]     mid_max,
    input  wire logic                          mask_rdata,
    input  wire logic [gcb_pkg::DIST_W-1:0]    dist_rdata,
    output gcb_pkg::scan_ram_t                 ram,
    output logic                               busy,
    output logic                               done
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FRD  = 8'b0000_0010,
        S_FWR  = 8'b0000_0100,
        S_BRD0 = 8'b0000_1000,
        S_BRD1 = 8'b0001_0000,
        S_BWR  = 8'b0010_0000,
        S_FILL = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } scan_state_t;

    scan_state_t                    state_reg, state_next;
    logic [gcb_pkg::COORD_W-1:0]    x_reg, x_next;
    logic [gcb_pkg::COORD_W-1:0]    y_reg, y_next;
    logic                           any_clear_reg, any_clear_next;
    logic [gcb_pkg::DIST_W-1:0]     side_reg, side_next;
    logic [gcb_pkg::DIST_W-1:0]     cur_reg, cur_next;

    logic                           x_last, y_last, has_rt, has_dn;
    logic [gcb_pkg::COORD_W-1:0]    x_max, y_max;
    logic [gcb_pkg::DIST_W-1:0]     fwd_d, bwd_d, fill_d;

    assign x_last = (gcb_pkg::SIZE_W'(x_reg) + gcb_pkg::SIZE_W'(1)) == w_eff;
    assign y_last = (gcb_pkg::SIZE_W'(y_reg) + gcb_pkg::SIZE_W'(1)) == h_eff;
    assign has_rt = (gcb_pkg::SIZE_W'(x_reg) + gcb_pkg::SIZE_W'(1)) < w_eff;
    assign has_dn = (gcb_pkg::SIZE_W'(y_reg) + gcb_pkg::SIZE_W'(1)) < h_eff;
    assign x_max  = gcb_pkg::COORD_W'(w_eff - gcb_pkg::SIZE_W'(1));
    assign y_max  = gcb_pkg::COORD_W'(h_eff - gcb_pkg::SIZE_W'(1));
    assign fill_d = gcb_pkg::DIST_W'(mid_max) + gcb_pkg::DIST_W'(1);

    always_comb
    begin
        logic [gcb_pkg::DIST_W-1:0] d;
        d = gcb_pkg::DIST_SAT;
        if (y_reg != '0)
        begin
            d = gcb_pkg::min_dist(d, gcb_pkg::sat_inc(dist_rdata));
        end
        if (x_reg != '0)
        begin
            d = gcb_pkg::min_dist(d, gcb_pkg::sat_inc(side_reg));
        end
        fwd_d = mask_rdata ? d : '0;
    end

    always_comb
    begin
        logic [gcb_pkg::DIST_W-1:0] d;
        d = cur_reg;
        if (has_dn)
        begin
            d = gcb_pkg::min_dist(d, gcb_pkg::sat_inc(dist_rdata));
        end
        if (has_rt)
        begin
            d = gcb_pkg::min_dist(d, gcb_pkg::sat_inc(side_reg));
        end
        bwd_d = d;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        any_clear_next = any_clear_reg;
        side_next      = side_reg;
        cur_next       = cur_reg;
        ram            = '0;
        done           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next = '0;
                    y_next = '0;
                    if (w_eff == '0 || h_eff == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        any_clear_next = 1'b0;
                        state_next     = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                ram.mask_re    = 1'b1;
                ram.mask_raddr = gcb_pkg::pixel_addr(y_reg, x_reg);
                ram.dist_re    = (y_reg != '0);
                ram.dist_raddr = gcb_pkg::pixel_addr(y_reg - gcb_pkg::COORD_W'(1), x_reg);
                state_next     = S_FWR;
            end
            S_FWR:
            begin
                ram.dist_we    = 1'b1;
                ram.dist_waddr = gcb_pkg::pixel_addr(y_reg, x_reg);
                ram.dist_wdata = fwd_d;
                side_next      = fwd_d;
                any_clear_next = any_clear_reg | ~mask_rdata;
                state_next     = S_FRD;
                if (!x_last)
                begin
                    x_next = x_reg + gcb_pkg::COORD_W'(1);
                end
                else if (!y_last)
                begin
                    x_next = '0;
                    y_next = y_reg + gcb_pkg::COORD_W'(1);
                end
                else if (any_clear_reg || !mask_rdata)
                begin
                    x_next     = x_max;
                    y_next     = y_max;
                    state_next = S_BRD0;
                end
                else
                begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_FILL;
                end
            end
            S_BRD0:
            begin
                ram.dist_re    = 1'b1;
                ram.dist_raddr = gcb_pkg::pixel_addr(y_reg, x_reg);
                state_next     = S_BRD1;
            end
            S_BRD1:
            begin
                cur_next       = dist_rdata;
                ram.dist_re    = has_dn;
                ram.dist_raddr = gcb_pkg::pixel_addr(y_reg + gcb_pkg::COORD_W'(1), x_reg);
                state_next     = S_BWR;
            end
            S_BWR:
            begin
                ram.dist_we    = 1'b1;
                ram.dist_waddr = gcb_pkg::pixel_addr(y_reg, x_reg);
                ram.dist_wdata = bwd_d;
                side_next      = bwd_d;
                state_next     = S_BRD0;
                if (x_reg != '0)
                begin
                    x_next = x_reg - gcb_pkg::COORD_W'(1);
                end
                else if (y_reg != '0)
                begin
                    x_next = x_max;
                    y_next = y_reg - gcb_pkg::COORD_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                ram.dist_we    = 1'b1;
                ram.dist_waddr = gcb_pkg::pixel_addr(y_reg, x_reg);
                ram.dist_wdata = fill_d;
                if (!x_last)
                begin
                    x_next = x_reg + gcb_pkg::COORD_W'(1);
                end
                else if (!y_last)
                begin
                    x_next = '0;
                    y_next = y_reg + gcb_pkg::COORD_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_ack)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            any_clear_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            any_clear_reg <= any_clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        side_reg <= side_next;
        cur_reg  <= cur_next;
    end

endmodule

`default_nettype wire

// ----- hdl/grid_city_block_distance_bands_unit.sv -----
// Writes, runs and reads take one item per cycle while item_stall is low; it
// is high during a transform and while s1 and the output register are full
// and result_stall is high. A read result passes through stage s1, where the
// registered distance memory read arrives, then the output register. A run
// command holds the item channel stalled for its whole transform: a forward
// scan that reads the distance memory up to once per pixel, then a backward
// scan that reads it up to twice (a fill of mid_max + 1 when no pixel is clear).
// Its single read port sets this pace. There is no clearing pass after reset.
//
// Top level of the grid city-block distance band unit: command path, config
// registers and output register. Depends on gcb_pkg, gcb_ram, gcb_scan and the macro header.
`default_nettype none
`include "grid_city_block_distance_bands_unit_macros.svh"

module grid_city_block_distance_bands_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gcb_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic [gcb_pkg::OP_W-1:0]         opcode,
    input  wire logic [gcb_pkg::COORD_W-1:0]      col,
    input  wire logic [gcb_pkg::COORD_W-1:0]      row,
    input  wire logic                             mask_bit,

    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic      [gcb_pkg::DIST_W-1:0]       distance,
    output logic      [gcb_pkg::BAND_W-1:0]       band,
    output logic                                  read_valid,
    output logic                                  out_of_range
);

    logic [gcb_pkg::SIZE_W-1:0] grid_width_reg, grid_height_reg;
    logic [gcb_pkg::THR_W-1:0]  edge_max_reg, mid_max_reg;
    logic [gcb_pkg::SIZE_W-1:0] w_eff, h_eff;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_read_reg, s1_read_next;
    logic                       s1_oor_reg, s1_oor_next;

    logic                       result_valid_reg, result_valid_next;
    logic [gcb_pkg::DIST_W-1:0] distance_reg, distance_next;
    logic [gcb_pkg::BAND_W-1:0] band_reg, band_next;
    logic                       read_valid_reg, read_valid_next;
    logic                       oor_reg, oor_next;

    logic                       item_take, s1_move, in_grid, is_access;
    logic                       scan_busy, scan_done, scan_start;
    gcb_pkg::scan_ram_t         scan_ram;

    logic                       mask_we, mask_rdata;
    logic [gcb_pkg::ADDR_W-1:0] cmd_addr, dist_raddr;
    logic                       dist_re;
    logic [gcb_pkg::DIST_W-1:0] dist_rdata;
    logic [gcb_pkg::DIST_W-1:0] rd_dist;

    assign w_eff = (grid_width_reg  > gcb_pkg::COLS_LIM) ? gcb_pkg::COLS_LIM : grid_width_reg;
    assign h_eff = (grid_height_reg > gcb_pkg::ROWS_LIM) ? gcb_pkg::ROWS_LIM : grid_height_reg;

    assign cfg_ready = 1'b1;

    assign s1_move    = !result_valid_reg || !result_stall;
    assign item_stall = scan_busy || (s1_valid_reg && !s1_move);
    assign item_take  = item_valid && !item_stall;

    assign in_grid   = (gcb_pkg::SIZE_W'(col) < w_eff) && (gcb_pkg::SIZE_W'(row) < h_eff);
    assign is_access = (opcode == gcb_pkg::OP_WRITE) || (opcode == gcb_pkg::OP_READ);
    assign cmd_addr  = gcb_pkg::pixel_addr(row, col);

    assign scan_start = item_take && (opcode == gcb_pkg::OP_RUN);
    assign mask_we    = item_take && (opcode == gcb_pkg::OP_WRITE) && in_grid;
    assign dist_re    = scan_ram.dist_re ||
                        (item_take && (opcode == gcb_pkg::OP_READ) && in_grid);
    assign dist_raddr = scan_busy ? scan_ram.dist_raddr : cmd_addr;

    gcb_ram #(
        .WIDTH (1),
        .DEPTH (gcb_pkg::DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (cmd_addr),
        .wdata (mask_bit),
        .re    (scan_ram.mask_re),
        .raddr (scan_ram.mask_raddr),
        .rdata (mask_rdata)
    );

    gcb_ram #(
        .WIDTH (gcb_pkg::DIST_W),
        .DEPTH (gcb_pkg::DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (scan_ram.dist_we),
        .waddr (scan_ram.dist_waddr),
        .wdata (scan_ram.dist_wdata),
        .re    (dist_re),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    gcb_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .done_ack   (!s1_valid_reg),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .mid_max    (mid_max_reg),
        .mask_rdata (mask_rdata),
        .dist_rdata (dist_rdata),
        .ram        (scan_ram),
        .busy       (scan_busy),
        .done       (scan_done)
    );

    // one result per item: stage s1 waits on read data, then the output register
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_move;
        s1_read_next  = s1_read_reg;
        s1_oor_next   = s1_oor_reg;
        if (scan_done)
        begin
            s1_valid_next = 1'b1;
            s1_read_next  = 1'b0;
            s1_oor_next   = 1'b0;
        end
        else if (item_take && !scan_start)
        begin
            s1_valid_next = 1'b1;
            s1_read_next  = (opcode == gcb_pkg::OP_READ);
            s1_oor_next   = is_access && !in_grid;
        end
    end

    assign rd_dist = (s1_read_reg && !s1_oor_reg) ? dist_rdata : '0;

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        distance_next     = distance_reg;
        band_next         = band_reg;
        read_valid_next   = read_valid_reg;
        oor_next          = oor_reg;
        if (s1_valid_reg && s1_move)
        begin
            result_valid_next = 1'b1;
            distance_next     = rd_dist;
            read_valid_next   = s1_read_reg;
            oor_next          = s1_oor_reg;
            priority if (rd_dist == '0)
            begin
                band_next = gcb_pkg::BAND_NONE;
            end
            else if (rd_dist <= gcb_pkg::DIST_W'(edge_max_reg))
            begin
                band_next = gcb_pkg::BAND_EDGE;
            end
            else if (rd_dist <= gcb_pkg::DIST_W'(mid_max_reg))
            begin
                band_next = gcb_pkg::BAND_MID;
            end
            else
            begin
                band_next = gcb_pkg::BAND_DEEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= gcb_pkg::RST_GRID_WIDTH;
            grid_height_reg  <= gcb_pkg::RST_GRID_HEIGHT;
            edge_max_reg     <= gcb_pkg::RST_EDGE_MAX;
            mid_max_reg      <= gcb_pkg::RST_MID_MAX;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gcb_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    gcb_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    gcb_pkg::CFG_EDGE_MAX:    edge_max_reg    <= cfg_data[gcb_pkg::THR_W-1:0];
                    gcb_pkg::CFG_MID_MAX:     mid_max_reg     <= cfg_data[gcb_pkg::THR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_read_reg    <= s1_read_next;
        s1_oor_reg     <= s1_oor_next;
        distance_reg   <= distance_next;
        band_reg       <= band_next;
        read_valid_reg <= read_valid_next;
        oor_reg        <= oor_next;
    end

    assign result_valid = result_valid_reg;
    assign distance     = distance_reg;
    assign band         = band_reg;
    assign read_valid   = read_valid_reg;
    assign out_of_range = oor_reg;

    `GCB_ASSERT_NOW(a_no_transfer_in_scan, item_valid && !item_stall, !scan_busy)
    `GCB_ASSERT_NEXT(a_run_starts_scan, item_take && opcode == gcb_pkg::OP_RUN, scan_busy)
    `GCB_ASSERT_NOW(a_done_into_empty_stage, scan_done, !s1_valid_reg)
    `GCB_ASSERT_NOW(a_oor_result_clear, result_valid && out_of_range, distance == '0 && band == gcb_pkg::BAND_NONE)

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for grid_city_block_distance_bands_unit: mask writes, transform runs and
// pixel reads, checked against a built-in distance/band scoreboard. Depends on gcb_pkg and the RTL.

module tb;
    import gcb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 750;
    localparam int IDLE_FREE_FROM = 600;
    localparam int LONG_HOLD      = 150;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [BAND_W-1:0] band;
        logic              read_valid;
        logic              out_of_range;
    } pixel_answer_t;

    class distance_band_board;
        bit                mask_mem [DEPTH];
        bit   [DIST_W-1:0] dist_mem [DEPTH];
        bit   [SIZE_W-1:0] width_reg;
        bit   [SIZE_W-1:0] height_reg;
        bit   [THR_W-1:0]  edge_reg;
        bit   [THR_W-1:0]  mid_reg;
        pixel_answer_t     answers_due[$];
        int                errors;

        function new();
            width_reg  = RST_GRID_WIDTH;
            height_reg = RST_GRID_HEIGHT;
            edge_reg   = RST_EDGE_MAX;
            mid_reg    = RST_MID_MAX;
            errors     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_WIDTH:  width_reg  = data[SIZE_W-1:0];
                CFG_GRID_HEIGHT: height_reg = data[SIZE_W-1:0];
                CFG_EDGE_MAX:    edge_reg   = data[THR_W-1:0];
                CFG_MID_MAX:     mid_reg    = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int cols_in_use();
            return (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
        endfunction

        function int rows_in_use();
            return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
        endfunction

        function bit [DIST_W-1:0] step_out(bit [DIST_W-1:0] d);
            return (d == DIST_SAT) ? d : d + 1'b1;
        endfunction

        function bit [DIST_W-1:0] nearer(bit [DIST_W-1:0] a, bit [DIST_W-1:0] b);
            return (a < b) ? a : b;
        endfunction

        function logic [BAND_W-1:0] band_of(bit [DIST_W-1:0] d);
            if (d == 0)
                return BAND_NONE;
            if (d <= edge_reg)
                return BAND_EDGE;
            if (d <= mid_reg)
                return BAND_MID;
            return BAND_DEEP;
        endfunction

        // forward then backward raster scan; all-set grid gets mid + 1
        function void spread_distances();
            int w, h, x, y, i;
            bit found;
            bit [DIST_W-1:0] d;
            w = cols_in_use();
            h = rows_in_use();
            found = 0;
            if (w == 0 || h == 0)
                return;
            for (y = 0; y < h; y++)
                for (x = 0; x < w; x++)
                begin
                    i = y * MAX_COLS + x;
                    if (!mask_mem[i])
                    begin
                        d = 0;
                        found = 1;
                    end
                    else
                    begin
                        d = DIST_SAT;
                        if (y > 0)
                            d = nearer(d, step_out(dist_mem[i - MAX_COLS]));
                        if (x > 0)
                            d = nearer(d, step_out(dist_mem[i - 1]));
                    end
                    dist_mem[i] = d;
                end
            if (!found)
            begin
                for (y = 0; y < h; y++)
                    for (x = 0; x < w; x++)
                        dist_mem[y * MAX_COLS + x] = DIST_W'(mid_reg) + 1'b1;
                return;
            end
            for (y = h - 1; y >= 0; y--)
                for (x = w - 1; x >= 0; x--)
                begin
                    i = y * MAX_COLS + x;
                    d = dist_mem[i];
                    if (y + 1 < h)
                        d = nearer(d, step_out(dist_mem[i + MAX_COLS]));
                    if (x + 1 < w)
                        d = nearer(d, step_out(dist_mem[i + 1]));
                    dist_mem[i] = d;
                end
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [COORD_W-1:0] c,
                                   logic [COORD_W-1:0] r, logic m);
            pixel_answer_t a;
            bit in_grid;
            int idx;
            a = '{default: '0};
            in_grid = (c < cols_in_use()) && (r < rows_in_use());
            idx = int'(r) * MAX_COLS + int'(c);
            case (op)
                OP_WRITE:
                    if (in_grid)
                        mask_mem[idx] = m;
                    else
                        a.out_of_range = 1'b1;
                OP_RUN:
                    spread_distances();
                OP_READ:
                begin
                    a.read_valid = 1'b1;
                    if (in_grid)
                    begin
                        a.distance = dist_mem[idx];
                        a.band     = band_of(dist_mem[idx]);
                    end
                    else
                        a.out_of_range = 1'b1;
                end
                default: ;
            endcase
            answers_due.insert(answers_due.size(), a);
        endfunction

        function void report(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_answer(logic [DIST_W-1:0] d, logic [BAND_W-1:0] b,
                                   logic rv, logic oor);
            pixel_answer_t e;
            if (answers_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got distance %0d band %0d",
                         $time, d, b);
                return;
            end
            e = answers_due.pop_front();
            if (d !== e.distance)
                report("distance", e.distance, d);
            if (b !== e.band)
                report("band", e.band, b);
            if (rv !== e.read_valid)
                report("read_valid", e.read_valid, rv);
            if (oor !== e.out_of_range)
                report("out_of_range", e.out_of_range, oor);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_stall;
    logic [OP_W-1:0]       opcode;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    logic                  mask_bit;
    logic                  result_valid;
    logic                  result_stall;
    logic [DIST_W-1:0]     distance;
    logic [BAND_W-1:0]     band;
    logic                  read_valid;
    logic                  out_of_range;

    grid_city_block_distance_bands_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .col          (col),
        .row          (row),
        .mask_bit     (mask_bit),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance),
        .band         (band),
        .read_valid   (read_valid),
        .out_of_range (out_of_range)
    );

    distance_band_board board;
    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int items_sent = 0;
    int cycles = 0;
    int cur_w;
    int cur_h;
    bit dist_known [DEPTH];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_register(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                board.note_command(opcode, col, row, mask_bit);
            if (result_valid && !result_stall)
                board.check_answer(distance, band, read_valid, out_of_range);
        end

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        int n;
        bit hold;
        bit s;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = hold_req;
            if (hold)
            begin
                s = 1'b1;
                n = LONG_HOLD;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                s = 1'b1;
                n = $urandom_range(1, 16);
            end
            else
            begin
                s = 1'b0;
                n = $urandom_range(1, 12);
            end
            result_stall <= s;
            repeat (n) @(posedge clk);
            if (hold)
                hold_req = 1'b0;
        end
    end

    function automatic bit read_ok(int c, int r);
        return !(c < cur_w && r < cur_h) || dist_known[r * MAX_COLS + c];
    endfunction

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h, input int e, input int m);
        put_register(CFG_GRID_WIDTH, w);
        put_register(CFG_GRID_HEIGHT, h);
        put_register(CFG_EDGE_MAX, ($urandom_range(0, 31) << THR_W) | e);
        put_register(CFG_MID_MAX, ($urandom_range(0, 31) << THR_W) | m);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_w = (w > MAX_COLS) ? MAX_COLS : w;
        cur_h = (h > MAX_ROWS) ? MAX_ROWS : h;
    endtask

    task automatic send(input logic [OP_W-1:0] op, input int c, input int r, input logic m);
        int x, y;
        if (tx_idle && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        col        <= c[COORD_W-1:0];
        row        <= r[COORD_W-1:0];
        mask_bit   <= m;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (op == OP_RUN)
            for (y = 0; y < cur_h; y++)
                for (x = 0; x < cur_w; x++)
                    dist_known[y * MAX_COLS + x] = 1'b1;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic noise_item();
        int c, r, sel;
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
        sel = $urandom_range(0, 2);
        if (sel == 0)
            send(OP_WRITE, c, r, 1'($urandom_range(0, 1)));
        else if (sel == 1 && read_ok(c, r))
            send(OP_READ, c, r, 1'($urandom_range(0, 1)));
        else
            send(OP_UNUSED, c, r, 1'($urandom_range(0, 1)));
    endtask

    // configure, write a whole mask, run, then read back with some noise mixed in
    task automatic run_phase(input int phase_no);
        int w, h, kind, density, c, r, n;
        bit m;
        drain();
        kind = (phase_no == 0) ? 1 : (phase_no == 1) ? 0 : $urandom_range(0, 39);
        case (kind)
            0:
                if ($urandom_range(0, 1))
                begin
                    w = 0;
                    h = $urandom_range(1, 511);
                end
                else
                begin
                    w = $urandom_range(1, 511);
                    h = 0;
                end
            1:
            begin
                w = $urandom_range(256, 511);
                h = 1;
            end
            2:
            begin
                w = 1;
                h = $urandom_range(256, 511);
            end
            default:
            begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 10);
            end
        endcase
        if (phase_no == 0)
            set_grid(w, h, 0, 15);
        else
            set_grid(w, h, $urandom_range(0, 15), $urandom_range(0, 15));
        if (items_sent < IDLE_FREE_FROM)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
        end
        else
        begin
            tx_idle = 1'b0;
            rx_idle = 1'b0;
        end
        density = (kind == 1 || kind == 2) ? -1 : $urandom_range(0, 12);
        for (r = 0; r < cur_h; r++)
            for (c = 0; c < cur_w; c++)
            begin
                if ($urandom_range(0, 11) == 0)
                    noise_item();
                case (density)
                    -1:      m = (c + r < 4) ? 1'($urandom_range(0, 1)) : 1'b1;
                    0:       m = 1'b1;
                    1:       m = 1'b0;
                    default: m = $urandom_range(0, density - 1) != 0;
                endcase
                send(OP_WRITE, c, r, m);
            end
        repeat ($urandom_range(1, 2))
        begin
            send(OP_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                 1'($urandom_range(0, 1)));
            if (cur_w > 0 && cur_h > 0)
                send(OP_READ, cur_w - 1, cur_h - 1, 1'($urandom_range(0, 1)));
            if (items_sent < IDLE_FREE_FROM && (phase_no == 2 || $urandom_range(0, 9) == 0))
                hold_req = 1'b1;
            n = $urandom_range(8, 30);
            repeat (n)
            begin
                if (cur_w > 0 && cur_h > 0 && $urandom_range(0, 9) < 7)
                    send(OP_READ, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                         1'($urandom_range(0, 1)));
                else
                    noise_item();
            end
        end
    endtask

    initial
    begin
        int phase_no;
        board = new();
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        opcode     <= OP_WRITE;
        col        <= '0;
        row        <= '0;
        mask_bit   <= 1'b0;
        cur_w = MAX_COLS;
        cur_h = MAX_ROWS;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused opcode, corner write on the reset-size grid
        send(OP_UNUSED, 255, 0, 1'b1);
        send(OP_WRITE, 255, 255, 1'b1);
        drain();

        // 3x2 grid, one clear corner: distances 0..3 across all four bands
        set_grid(3, 2, 1, 2);
        send(OP_WRITE, 0, 0, 1'b0);
        send(OP_WRITE, 1, 0, 1'b1);
        send(OP_WRITE, 2, 0, 1'b1);
        send(OP_WRITE, 0, 1, 1'b1);
        send(OP_WRITE, 1, 1, 1'b1);
        send(OP_WRITE, 2, 1, 1'b1);
        send(OP_WRITE, 0, 2, 1'b0);
        send(OP_RUN, 0, 0, 1'b0);
        send(OP_READ, 2, 1, 1'b0);
        send(OP_READ, 1, 0, 1'b1);
        send(OP_READ, 0, 0, 1'b0);
        send(OP_READ, 2, 0, 1'b0);
        send(OP_READ, 3, 0, 1'b0);
        send(OP_READ, 255, 255, 1'b1);
        drain();

        // no clear pixel: fill with mid + 1; crossed thresholds put it in edge
        set_grid(2, 1, 15, 0);
        send(OP_WRITE, 0, 0, 1'b1);
        send(OP_WRITE, 1, 0, 1'b1);
        send(OP_RUN, 255, 255, 1'b1);
        send(OP_READ, 1, 0, 1'b0);
        send(OP_READ, 0, 0, 1'b1);
        drain();

        // empty grid: every access out of range, run is a no-op
        set_grid(0, 256, 2, 5);
        send(OP_WRITE, 0, 0, 1'b0);
        send(OP_RUN, 0, 0, 1'b0);
        send(OP_READ, 0, 0, 1'b0);

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.answers_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
